[hw/rtl/rarm_pkg.sv]
// Shared types and constants for the rational add/multiply/reduce block.
// Depends on nothing; every other file imports it.
package rarm_pkg;

  // Operand width of the numerators; denominators are one bit narrower.
  localparam int OPERAND_WIDTH = 16;

  // Full multiplier product of two sign-extended operands.
  localparam int PROD_W = 2 * OPERAND_WIDTH + 2;
  // Raw signed numerator.
  localparam int NUM_W  = 2 * OPERAND_WIDTH;
  // Magnitude of the raw numerator, also the divider width.
  localparam int MAG_W  = 2 * OPERAND_WIDTH - 1;
  // Raw denominator product.
  localparam int DEN_W  = 2 * OPERAND_WIDTH - 2;
  // Divider step counter, wide enough to hold MAG_W itself.
  localparam int CNT_W  = $clog2(MAG_W + 1);
  // Working width for forming the output fields.
  localparam int WIDE_W = (MAG_W > 32) ? MAG_W : 32;

  // Output field widths are fixed.
  localparam int NUM_OUT_W = 32;
  localparam int DEN_OUT_W = 30;

  // Operation codes.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic                            req_type;
    logic signed [OPERAND_WIDTH-1:0] num_a;
    logic        [OPERAND_WIDTH-2:0] den_a;
    logic signed [OPERAND_WIDTH-1:0] num_b;
    logic        [OPERAND_WIDTH-2:0] den_b;
  } item_t;

  typedef struct packed {
    logic signed [NUM_OUT_W-1:0] num_out;
    logic        [DEN_OUT_W-1:0] den_out;
    logic                        bad_denominator;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SETUP,
    S_GCD,
    S_GCD_WAIT,
    S_DIVN,
    S_DIVN_WAIT,
    S_DIVD,
    S_DIVD_WAIT,
    S_DONE
  } state_t;

endpackage

[hw/rtl/rarm_mult.sv]
// Registered signed multiplier shared by all products of the block.
// Depends on rarm_pkg for the operand and product widths.
module rarm_mult
  import rarm_pkg::*;
(
  input  logic                          clk,
  input  logic signed [OPERAND_WIDTH:0] a,
  input  logic signed [OPERAND_WIDTH:0] b,
  output logic signed [PROD_W-1:0]      p
);

  // The product is evaluated at the full product width and registered.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[hw/rtl/rarm_div.sv]
// Restoring divider, one quotient bit per cycle, used for the Euclidean
// remainders and the final exact divisions. Depends on rarm_pkg.
module rarm_div
  import rarm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [MAG_W-1:0] divisor,
  output logic [MAG_W-1:0] quotient,
  output logic [MAG_W-1:0] remainder,
  output logic             done
);

  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [MAG_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;
  logic             ge;

  // One trial subtraction of the shifted partial remainder.
  always_comb begin
    shifted = {rem, quo[MAG_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  // Step control: MAG_W steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
      quo <= {quo[MAG_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[hw/rtl/rational_add_multiply_reduce.sv]
// Top level of the rational add/multiply/reduce block: sequencer, datapath
// registers and output register. Depends on rarm_pkg, rarm_mult, rarm_div.
//
// Usage: an input word on item (item_valid/item_ready) carries two fractions
// and an operation, add or multiply. One result word leaves on result
// (result_valid/result_ready) with the reduced fraction, or 0/1 and the
// bad_denominator flag when an input denominator is zero.
// The block works on one word at a time; item_ready is high only while the
// sequencer is idle. The products are formed by one registered multiplier.
// The gcd then runs through the shared one-bit-a-cycle divider, followed by
// two exact divisions on the same divider. A zero denominator goes straight
// from idle to the final state, and a zero numerator skips the gcd and the
// divisions. The next word is taken in the cycle after the result register
// loads, once the sequencer is back in idle.
// Reset (synchronous, active high) returns the sequencer to idle and empties
// the output register. A stalled receiver holds the result in the output
// register; the block still accepts and works on the next word, and waits
// in its final state until the output register is free.
module rational_add_multiply_reduce
  import rarm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  state_t state;
  state_t state_next;

  // Latched operands.
  logic                          op_mul;
  logic signed [OPERAND_WIDTH:0] na;
  logic signed [OPERAND_WIDTH:0] nb;
  logic signed [OPERAND_WIDTH:0] da;
  logic signed [OPERAND_WIDTH:0] db;

  // Datapath registers.
  logic signed [NUM_W-1:0] acc;
  logic signed [NUM_W-1:0] n;
  logic        [DEN_W-1:0] d;
  logic        [MAG_W-1:0] mag;
  logic                    neg;
  logic        [MAG_W-1:0] x;
  logic        [MAG_W-1:0] y;
  logic        [MAG_W-1:0] num_q;

  // Result held for the output register.
  logic [NUM_OUT_W-1:0] res_num;
  logic [DEN_OUT_W-1:0] res_den;
  logic                 res_bad;

  // Shared units.
  logic signed [OPERAND_WIDTH:0] mul_a;
  logic signed [OPERAND_WIDTH:0] mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic                          div_start;
  logic [MAG_W-1:0]              div_dividend;
  logic [MAG_W-1:0]              div_divisor;
  logic [MAG_W-1:0]              div_quo;
  logic [MAG_W-1:0]              div_rem;
  logic                          div_done;

  logic                    accept;
  logic                    bad_in;
  logic                    out_load;
  logic signed [NUM_W-1:0] n_abs;
  logic [WIDE_W-1:0]       den_wide;
  logic [WIDE_W-1:0]       numq_wide;

  rarm_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  rarm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign accept   = item_valid && item_ready;
  assign bad_in   = (item.den_a == '0) || (item.den_b == '0);
  assign out_load = (state == S_DONE) && (!result_valid || result_ready);

  // Magnitude of the raw numerator and the truncated denominator field.
  always_comb begin
    n_abs    = n[NUM_W-1] ? -n : n;
    den_wide = WIDE_W'(div_quo);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = bad_in ? S_DONE : S_MUL0;
        end
      end
      S_MUL0:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_SETUP;
      S_SETUP: state_next = (n == '0) ? S_DONE : S_GCD;
      S_GCD:   state_next = (y == '0) ? S_DIVN : S_GCD_WAIT;
      S_GCD_WAIT: begin
        if (div_done) begin
          state_next = S_GCD;
        end
      end
      S_DIVN: state_next = S_DIVN_WAIT;
      S_DIVN_WAIT: begin
        if (div_done) begin
          state_next = S_DIVD;
        end
      end
      S_DIVD: state_next = S_DIVD_WAIT;
      S_DIVD_WAIT: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs: handshake, multiplier operands and divider operands.
  always_comb begin
    item_ready   = 1'b0;
    mul_a        = na;
    mul_b        = nb;
    div_start    = 1'b0;
    div_dividend = x;
    div_divisor  = y;
    unique case (state)
      S_IDLE: item_ready = 1'b1;
      S_MUL0: begin
        mul_a = na;
        mul_b = (op_mul == OP_MUL) ? nb : db;
      end
      S_MUL1: begin
        mul_a = nb;
        mul_b = da;
      end
      S_MUL2: begin
        mul_a = da;
        mul_b = db;
      end
      S_GCD: begin
        div_start = (y != '0);
      end
      S_DIVN: begin
        div_start    = 1'b1;
        div_dividend = mag;
        div_divisor  = x;
      end
      S_DIVD: begin
        div_start    = 1'b1;
        div_dividend = MAG_W'(d);
        div_divisor  = x;
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, updated as the sequencer walks through the steps.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_mul  <= item.req_type;
          na      <= {item.num_a[OPERAND_WIDTH-1], item.num_a};
          nb      <= {item.num_b[OPERAND_WIDTH-1], item.num_b};
          da      <= {2'b00, item.den_a};
          db      <= {2'b00, item.den_b};
          res_num <= '0;
          res_den <= DEN_OUT_W'(1);
          res_bad <= bad_in;
        end
      end
      S_MUL1: acc <= prod[NUM_W-1:0];
      S_MUL2: n <= (op_mul == OP_MUL) ? acc : acc + prod[NUM_W-1:0];
      S_SETUP: begin
        d   <= prod[DEN_W-1:0];
        neg <= n[NUM_W-1];
        mag <= n_abs[MAG_W-1:0];
        x   <= n_abs[MAG_W-1:0];
        y   <= MAG_W'(prod[DEN_W-1:0]);
      end
      S_GCD_WAIT: begin
        if (div_done) begin
          x <= y;
          y <= div_rem;
        end
      end
      S_DIVN_WAIT: begin
        if (div_done) begin
          num_q <= div_quo;
        end
      end
      S_DIVD_WAIT: begin
        if (div_done) begin
          res_num <= numq_wide[NUM_OUT_W-1:0];
          res_den <= den_wide[DEN_OUT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Final sign and truncation of the reduced numerator held in num_q.
  always_comb begin
    numq_wide = WIDE_W'(num_q);
    if (neg) begin
      numq_wide = -numq_wide;
    end
  end

  // Output register; it frees as soon as the receiver takes the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.num_out         <= res_num;
      result.den_out         <= res_den;
      result.bad_denominator <= res_bad;
    end
  end

endmodule

[hw/rtl/rarm_checker.sv]
// Port-level checks for the rational add/multiply/reduce block, with the
// bind that attaches them to the top level. Depends on rarm_pkg.
module rarm_checker
  import rarm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result word holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // The block is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item_ready high right after an accepted word");

  // A flagged word is always 0/1.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_denominator |->
      result.num_out == '0 && result.den_out == DEN_OUT_W'(1))
    else $error("bad denominator word is not 0/1");

  // A zero numerator always comes with denominator one.
  a_zero_reduced: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.num_out == '0 |-> result.den_out == DEN_OUT_W'(1))
    else $error("zero numerator not reduced to 0/1");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set after reset");

endmodule

bind rational_add_multiply_reduce rarm_checker u_rarm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
